FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the quantile sketch.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qs_pkg.sv
// Package with the types and constants of the quantile sketch.
package qs_pkg;

    // Largest Q16.16 value marks an empty centroid slot.
    localparam logic [31:0] EMPTY_MEAN = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

    // Input word modes.
    localparam logic MODE_OBSERVE = 1'b0;
    localparam logic MODE_QUERY   = 1'b1;

    // Quotient bits produced by the divider, one per cycle.
    localparam int DIV_STEPS = 32;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_OINIT,
        S_OSTART,
        S_OLOAD,
        S_ORD,
        S_OEV,
        S_LRD,
        S_LEV,
        S_WSTART,
        S_WLOAD,
        S_WRD,
        S_WEV,
        S_WCLR,
        S_WTOP,
        S_FDIFF,
        S_FMUL,
        S_FSTART,
        S_FDIV,
        S_FDONE,
        S_QMUL,
        S_QTGT,
        S_QRD,
        S_QEV,
        S_QOUT
    } state_t;

    // Status reported by the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

FILE: rtl/qs_in_if.sv
// Input channel of the quantile sketch: observe or query words.
interface qs_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] sample;
    logic [16:0]        fraction;

    modport source (output valid, output mode, output sample, output fraction, input ready);
    modport sink   (input valid, input mode, input sample, input fraction, output ready);
endinterface

FILE: rtl/qs_out_if.sv
// Output channel of the quantile sketch: query answers.
interface qs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quantile_value;
    logic               empty_flag;

    modport source (output valid, output quantile_value, output empty_flag, input ready);
    modport sink   (input valid, input quantile_value, input empty_flag, output ready);
endinterface

FILE: rtl/streaming_quantile_sketch.sv
// Top level of the streaming quantile sketch: sequencer, centroid and limit memories.
//
// The item channel takes words with mode 0 (observe sample) or mode 1 (query
// fraction, Q0.16 with 65536 meaning one). Only queries produce a word on the
// result channel: the mean of the first centroid whose running weight reaches
// ceil(total * fraction), and empty_flag when nothing was observed yet.
// One word is worked on at a time; item.ready is high while the sequencer idles.
// Centroids and limits sit in two memories with registered reads, walked one
// bucket at a time by the sequencer, a read and an evaluate state per bucket.
// Query: a multiply and a target step, then bucket reads until the running
// weight reaches the target or the last bucket; then the result register loads.
// Observe: a walk, then a mean update through the 32-step divider. When the last
// bucket is full, a widening pass runs, with a mean update per merged pair.
// The result sits in an output register, so the next word is taken while the
// answer waits; a query that finishes while the receiver stalls holds until
// the register frees up. Reset empties all buckets, sets all limits to one and
// clears the count; the memories use written flags, so no clearing pass runs.
`include "assert_macros.svh"

module streaming_quantile_sketch #(
    parameter int NUM_BUCKETS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    qs_in_if.sink  item,
    qs_out_if.source result
);
    import qs_pkg::*;

    localparam int              IDX_W = $clog2(NUM_BUCKETS);
    localparam int              RUN_W = 32 + IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BUCKETS - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_inc;
    logic [31:0]        total_reg;
    logic signed [31:0] smp_reg;
    logic [16:0]        frac_reg;
    logic signed [31:0] cm_reg, cur_m_reg;
    logic [31:0]        cw_reg, cur_w_reg;
    logic signed [31:0] fm1_reg, fm2_reg;
    logic [31:0]        fw1_reg, fw2_reg;
    logic [31:0]        mag_reg, wsum_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic               ctx_widen_reg;
    logic [31:0]        lim_top_reg;
    logic [48:0]        qprod_reg;
    logic [32:0]        tgt_reg;
    logic [RUN_W-1:0]   run_reg;
    logic signed [31:0] res_m_reg;
    logic               res_e_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_val_reg;
    logic               out_emp_reg;

    // Memory ports.
    logic [63:0]      cen_rd, cen_wdata;
    logic             cen_we;
    logic [IDX_W-1:0] cen_raddr, cen_waddr;
    logic [31:0]      lim_rd, lim_wdata;
    logic             lim_we;
    logic [IDX_W-1:0] lim_raddr, lim_waddr;

    // Divider.
    logic        div_start;
    logic [31:0] div_q;
    div_status_t div_stat;

    // Evaluation terms.
    logic signed [31:0] nm;
    logic [31:0]        nw;
    logic               o_lt_next, o_fit, o_lt_cur, o_fold, o_trade;
    logic [31:0]        o_cw_after;
    logic               l_fit, l_trade;
    logic               w_merge;
    logic [RUN_W-1:0]   q_run;
    logic               q_hit;
    logic               out_free;
    logic signed [32:0] diff33;
    logic [32:0]        ndiff33;
    logic signed [32:0] fres33;
    logic signed [31:0] fres_m;
    logic [31:0]        fres_w;

    qs_ram #(
        .WIDTH    (64),
        .DEPTH    (NUM_BUCKETS),
        .RESET_VAL({EMPTY_MEAN, 32'd0})
    ) u_cen (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (cen_we),
        .waddr(cen_waddr),
        .wdata(cen_wdata),
        .raddr(cen_raddr),
        .rdata(cen_rd)
    );

    qs_ram #(
        .WIDTH    (32),
        .DEPTH    (NUM_BUCKETS),
        .RESET_VAL(32'd1)
    ) u_lim (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (lim_we),
        .waddr(lim_waddr),
        .wdata(lim_wdata),
        .raddr(lim_raddr),
        .rdata(lim_rd)
    );

    qs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(prod_reg),
        .divisor (wsum_reg),
        .quotient(div_q),
        .status  (div_stat)
    );

    // Decisions for the current bucket.
    assign idx_inc    = idx_reg + 1'b1;
    assign nm         = cen_rd[63:32];
    assign nw         = cen_rd[31:0];
    assign o_lt_next  = cm_reg < nm;
    assign o_fit      = {1'b0, lim_rd} >= ({1'b0, cur_w_reg} + {1'b0, cw_reg});
    assign o_lt_cur   = cm_reg < cur_m_reg;
    assign o_fold     = o_lt_next && o_fit;
    assign o_trade    = o_lt_next && !o_fit && o_lt_cur;
    assign o_cw_after = o_trade ? cur_w_reg : cw_reg;
    assign l_fit      = lim_rd > cur_w_reg;
    assign l_trade    = !l_fit && o_lt_cur;
    assign w_merge    = ({1'b0, cur_w_reg} + {1'b0, nw}) <= {1'b0, lim_rd};
    assign q_run      = run_reg + RUN_W'(nw);
    assign q_hit      = (q_run >= RUN_W'(tgt_reg)) || (idx_reg == LAST);
    assign out_free   = !out_valid_reg || result.ready;

    // Mean update arithmetic: difference, then the truncated step toward m1.
    assign diff33  = {fm2_reg[31], fm2_reg} - {fm1_reg[31], fm1_reg};
    assign ndiff33 = ~diff33 + 1'b1;
    assign fres33  = neg_reg ? ({fm1_reg[31], fm1_reg} - {1'b0, div_q})
                             : ({fm1_reg[31], fm1_reg} + {1'b0, div_q});
    assign fres_m  = (fw1_reg == 32'd0) ? fm2_reg : fres33[31:0];
    assign fres_w  = (fw1_reg == 32'd0) ? fw2_reg : wsum_reg;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.mode == MODE_QUERY)
                    begin
                        state_next = (total_reg == 32'd0) ? S_QOUT : S_QMUL;
                    end
                    else
                    begin
                        state_next = (total_reg == 32'd0) ? S_OINIT : S_OSTART;
                    end
                end
            end
            S_OINIT:  state_next = S_IDLE;
            S_OSTART: state_next = S_OLOAD;
            S_OLOAD:  state_next = S_ORD;
            S_ORD:    state_next = S_OEV;
            S_OEV:
            begin
                if (o_fold)
                begin
                    state_next = S_FDIFF;
                end
                else if (o_cw_after == 32'd0)
                begin
                    state_next = S_IDLE;
                end
                else if (idx_inc == LAST)
                begin
                    state_next = S_LRD;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_LRD:    state_next = S_LEV;
            S_LEV:    state_next = l_fit ? S_FDIFF : S_WSTART;
            S_WSTART: state_next = S_WLOAD;
            S_WLOAD:  state_next = S_WRD;
            S_WRD:    state_next = S_WEV;
            S_WEV:
            begin
                if (w_merge)
                begin
                    state_next = S_FDIFF;
                end
                else
                begin
                    state_next = (idx_inc == LAST) ? S_WTOP : S_WRD;
                end
            end
            S_WCLR:   state_next = (idx_inc == LAST) ? S_WTOP : S_WRD;
            S_WTOP:   state_next = S_FDIFF;
            S_FDIFF:  state_next = (fw1_reg == 32'd0) ? S_FDONE : S_FMUL;
            S_FMUL:   state_next = S_FSTART;
            S_FSTART: state_next = S_FDIV;
            S_FDIV:   state_next = div_stat.done ? S_FDONE : S_FDIV;
            S_FDONE:  state_next = ctx_widen_reg ? S_WCLR : S_IDLE;
            S_QMUL:   state_next = S_QTGT;
            S_QTGT:   state_next = S_QRD;
            S_QRD:    state_next = S_QEV;
            S_QEV:    state_next = q_hit ? S_QOUT : S_QRD;
            S_QOUT:   state_next = out_free ? S_IDLE : S_QOUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory ports, divider start.
    always_comb
    begin
        item.ready = 1'b0;
        div_start  = 1'b0;
        cen_raddr  = '0;
        cen_we     = 1'b0;
        cen_waddr  = idx_reg;
        cen_wdata  = {cm_reg, cw_reg};
        lim_raddr  = idx_reg;
        lim_we     = 1'b0;
        lim_waddr  = idx_reg;
        lim_wdata  = lim_rd;
        unique case (state_reg) inside
            S_IDLE:
            begin
                item.ready = 1'b1;
            end
            S_OINIT:
            begin
                cen_we    = 1'b1;
                cen_waddr = '0;
                cen_wdata = {smp_reg, 32'd1};
            end
            S_ORD, S_WRD:
            begin
                cen_raddr = idx_inc;
                lim_raddr = (state_reg == S_WRD) ? idx_inc : idx_reg;
            end
            S_OEV:
            begin
                cen_we = o_trade;
            end
            S_LRD:
            begin
                lim_raddr = LAST;
            end
            S_LEV:
            begin
                cen_we    = l_trade;
                cen_waddr = LAST;
            end
            S_WEV:
            begin
                lim_we = 1'b1;
            end
            S_WCLR:
            begin
                cen_we    = 1'b1;
                cen_waddr = idx_inc;
                cen_wdata = {EMPTY_MEAN, 32'd0};
            end
            S_WTOP:
            begin
                lim_we    = 1'b1;
                lim_waddr = LAST;
                lim_wdata = {lim_top_reg[30:0], 1'b0} | {32{lim_top_reg[31]}};
            end
            S_FSTART:
            begin
                div_start = 1'b1;
            end
            S_FDONE:
            begin
                cen_we    = 1'b1;
                cen_wdata = {fres_m, fres_w};
            end
            S_QRD:
            begin
                cen_raddr = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sample count, kept outside the memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (state_reg == S_IDLE && item.valid && item.mode == MODE_OBSERVE)
        begin
            total_reg <= sat_add32(total_reg, 32'd1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_QOUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_QOUT && out_free)
        begin
            out_val_reg <= res_m_reg;
            out_emp_reg <= res_e_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.quantile_value = out_val_reg;
    assign result.empty_flag     = out_emp_reg;

    // Working registers of the walk, widening pass, mean update and query.
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            S_IDLE:
            begin
                smp_reg   <= item.sample;
                frac_reg  <= item.fraction;
                cm_reg    <= item.sample;
                cw_reg    <= 32'd1;
                idx_reg   <= '0;
                run_reg   <= '0;
                res_m_reg <= EMPTY_MEAN;
                res_e_reg <= (total_reg == 32'd0);
            end
            S_OLOAD, S_WLOAD:
            begin
                cur_m_reg <= nm;
                cur_w_reg <= nw;
            end
            S_OEV:
            begin
                if (o_fold)
                begin
                    fm1_reg       <= cur_m_reg;
                    fw1_reg       <= cur_w_reg;
                    fm2_reg       <= cm_reg;
                    fw2_reg       <= cw_reg;
                    ctx_widen_reg <= 1'b0;
                end
                else
                begin
                    if (o_trade)
                    begin
                        cm_reg <= cur_m_reg;
                        cw_reg <= cur_w_reg;
                    end
                    cur_m_reg <= nm;
                    cur_w_reg <= nw;
                    idx_reg   <= idx_inc;
                end
            end
            S_LEV:
            begin
                fm1_reg       <= cur_m_reg;
                fw1_reg       <= cur_w_reg;
                fm2_reg       <= cm_reg;
                fw2_reg       <= cw_reg;
                ctx_widen_reg <= 1'b0;
                if (!l_fit)
                begin
                    idx_reg <= '0;
                    if (l_trade)
                    begin
                        cm_reg <= cur_m_reg;
                        cw_reg <= cur_w_reg;
                    end
                end
            end
            S_WEV:
            begin
                lim_top_reg <= lim_rd;
                if (w_merge)
                begin
                    fm1_reg       <= cur_m_reg;
                    fw1_reg       <= cur_w_reg;
                    fm2_reg       <= nm;
                    fw2_reg       <= nw;
                    ctx_widen_reg <= 1'b1;
                end
                else
                begin
                    cur_m_reg <= nm;
                    cur_w_reg <= nw;
                    idx_reg   <= idx_inc;
                end
            end
            S_WCLR:
            begin
                cur_m_reg <= EMPTY_MEAN;
                cur_w_reg <= 32'd0;
                idx_reg   <= idx_inc;
            end
            S_WTOP:
            begin
                fm1_reg       <= cur_m_reg;
                fw1_reg       <= cur_w_reg;
                fm2_reg       <= cm_reg;
                fw2_reg       <= cw_reg;
                ctx_widen_reg <= 1'b0;
                idx_reg       <= LAST;
            end
            S_FDIFF:
            begin
                neg_reg  <= diff33[32];
                mag_reg  <= diff33[32] ? ndiff33[31:0] : diff33[31:0];
                wsum_reg <= sat_add32(fw1_reg, fw2_reg);
            end
            S_FMUL:
            begin
                prod_reg <= fw2_reg * mag_reg;
            end
            S_QMUL:
            begin
                qprod_reg <= total_reg * frac_reg;
            end
            S_QTGT:
            begin
                tgt_reg <= 33'(({1'b0, qprod_reg} + 50'd65535) >> 16);
            end
            S_QEV:
            begin
                run_reg   <= q_run;
                res_m_reg <= nm;
                idx_reg   <= idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    // Checks on the sequencer.
    `QS_ASSERT_NOW(a_div_idle, clk, rst_n, div_start, !div_stat.busy, "divider started while busy")
    `QS_ASSERT_NEXT(a_widen_clear, clk, rst_n, state_reg == S_FDONE && ctx_widen_reg, state_reg == S_WCLR, "merged slot not cleared")
    `QS_ASSERT_NEXT(a_total_mono, clk, rst_n, 1'b1, total_reg >= $past(total_reg), "sample count went down")
    `QS_ASSERT_NEXT(a_hold_result, clk, rst_n, state_reg == S_QOUT && out_valid_reg && !result.ready, state_reg == S_QOUT && out_valid_reg, "pending result overwritten")
endmodule

FILE: rtl/qs_ram.sv
// Single-port-write, single-port-read memory with registered read and reset valid bits.
module qs_ram #(
    parameter int               WIDTH     = 32,
    parameter int               DEPTH     = 16,
    parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_reg;
    logic             rv_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Written flags; an entry never written reads as the reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rv_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rv_reg ? rd_reg : RESET_VAL;
endmodule

FILE: rtl/qs_div.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit 32 bits.
module qs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         dividend,
    input  logic [31:0]         divisor,
    output logic [31:0]         quotient,
    output qs_pkg::div_status_t status
);
    import qs_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [31:0]      rem_reg;
    logic [31:0]      lo_reg;
    logic [31:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, lo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    // Control: count steps and flag completion for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the upper half is below the divisor, so only 32 steps are needed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            lo_reg  <= dividend[31:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            lo_reg  <= {lo_reg[30:0], fits};
        end
    end

    assign quotient    = lo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule

FILE: bench/qs_checker.sv
// Checker that predicts the quantile sketch answers and compares the result words.
module qs_checker #(
    parameter int NUM_BUCKETS = 16
) (
    input  logic clk,
    input  logic rst_n,
    qs_in_if     item,
    qs_out_if    result,
    output int   fail_count,
    output int   pending,
    output int   observe_count,
    output int   query_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import qs_pkg::*;

    typedef struct packed {
        logic signed [31:0] quantile_value;
        logic               empty_flag;
    } answer_t;

    // Model copy of the sketch state.
    logic signed [31:0] mean_row [NUM_BUCKETS];
    logic [31:0]        weight_row [NUM_BUCKETS];
    logic [31:0]        limit_row [NUM_BUCKETS];
    logic [31:0]        seen_total;

    answer_t answer_queue [$];

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

    // Weighted mean update, truncated toward the old mean.
    function automatic void blend(inout logic signed [31:0] m1, inout logic [31:0] w1,
                                  input logic signed [31:0] m2, input logic [31:0] w2);
        logic [31:0] w;
        longint      d;
        logic [63:0] mag;
        logic [63:0] q;
        if (w1 == 0)
        begin
            w1 = w2;
            m1 = m2;
            return;
        end
        w = add_sat(w1, w2);
        d = longint'(m2) - longint'(m1);
        mag = (d < 0) ? -d : d;
        q = ({32'd0, w2} * mag) / {32'd0, w};
        if (d < 0)
            m1 = 32'(longint'(m1) - longint'(q));
        else
            m1 = 32'(longint'(m1) + longint'(q));
        w1 = w;
    endfunction

    // Shift capacities down, double the top and merge neighbors that fit.
    function automatic void widen_row();
        logic [63:0] top;
        logic [63:0] both;
        top = {32'd0, limit_row[NUM_BUCKETS-1]} * 2;
        for (int i = 0; i < NUM_BUCKETS - 1; i++)
            limit_row[i] = limit_row[i+1];
        limit_row[NUM_BUCKETS-1] = (top > {32'd0, SAT32}) ? SAT32 : top[31:0];
        for (int i = 0; i < NUM_BUCKETS - 1; i++)
        begin
            both = {32'd0, weight_row[i]} + {32'd0, weight_row[i+1]};
            if (both <= {32'd0, limit_row[i]})
            begin
                blend(mean_row[i], weight_row[i], mean_row[i+1], weight_row[i+1]);
                mean_row[i+1] = EMPTY_MEAN;
                weight_row[i+1] = 0;
            end
        end
    endfunction

    // Insert one sample into the centroid row.
    function automatic void insert_sample(input logic signed [31:0] v);
        logic signed [31:0] cm;
        logic [31:0]        cw;
        logic signed [31:0] tm;
        logic [31:0]        tw;
        int                 last;
        cm = v;
        cw = 1;
        last = NUM_BUCKETS - 1;
        seen_total = add_sat(seen_total, 1);
        if (seen_total == 1)
        begin
            mean_row[0] = v;
            weight_row[0] = 1;
            return;
        end
        for (int i = 0; i < last; i++)
        begin
            if (cm < mean_row[i+1])
            begin
                if ({32'd0, limit_row[i]} >= {32'd0, weight_row[i]} + {32'd0, cw})
                begin
                    blend(mean_row[i], weight_row[i], cm, cw);
                    return;
                end
                if (cm < mean_row[i])
                begin
                    tm = cm; tw = cw;
                    cm = mean_row[i]; cw = weight_row[i];
                    mean_row[i] = tm; weight_row[i] = tw;
                end
            end
            if (cw == 0)
                return;
        end
        if (limit_row[last] > weight_row[last])
        begin
            blend(mean_row[last], weight_row[last], cm, cw);
            return;
        end
        if (cm < mean_row[last])
        begin
            tm = cm; tw = cw;
            cm = mean_row[last]; cw = weight_row[last];
            mean_row[last] = tm; weight_row[last] = tw;
        end
        widen_row();
        blend(mean_row[last], weight_row[last], cm, cw);
    endfunction

    // Mean of the first centroid whose running weight reaches the target.
    function automatic logic signed [31:0] locate_quantile(input logic [16:0] frac);
        logic [63:0] target;
        logic [63:0] run;
        target = ({32'd0, seen_total} * {47'd0, frac} + 64'd65535) >> 16;
        run = 0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            run += {32'd0, weight_row[i]};
            if (run >= target)
                return mean_row[i];
        end
        return mean_row[NUM_BUCKETS-1];
    endfunction

    assign pending = answer_queue.size();

    // Predict on accepted input words, compare accepted result words.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                mean_row[i] = EMPTY_MEAN;
                weight_row[i] = 0;
                limit_row[i] = 1;
            end
            seen_total = 0;
            answer_queue.delete();
            fail_count <= 0;
            observe_count <= 0;
            query_count <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (answer_queue.size() == 0)
                begin
                    $error("unexpected result word: value %h empty %b",
                           result.quantile_value, result.empty_flag);
                    errs++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (want.quantile_value !== result.quantile_value)
                    begin
                        $error("quantile_value: expected %h, actual %h",
                               want.quantile_value, result.quantile_value);
                        errs++;
                    end
                    if (want.empty_flag !== result.empty_flag)
                    begin
                        $error("empty_flag: expected %b, actual %b",
                               want.empty_flag, result.empty_flag);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (item.valid && item.ready)
            begin
                if (item.mode == MODE_OBSERVE)
                begin
                    insert_sample(item.sample);
                    observe_count <= observe_count + 1;
                end
                else
                begin
                    if (seen_total == 0)
                        want = '{quantile_value: EMPTY_MEAN, empty_flag: 1'b1};
                    else
                        want = '{quantile_value: locate_quantile(item.fraction),
                                 empty_flag: 1'b0};
                    answer_queue.push_back(want);
                    query_count <= query_count + 1;
                end
            end
        end
    end
endmodule

FILE: bench/tb.sv
// Top of the quantile sketch testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qs_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 1500;
    localparam int RANDOM_WORDS   = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   observe_count;
    int   query_count;
    int   tx_idle_pct = 28;
    int   rx_idle_pct = 78;
    int   quiet_cycles = 0;

    qs_in_if  item ();
    qs_out_if result ();

    streaming_quantile_sketch #(.NUM_BUCKETS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    qs_checker #(.NUM_BUCKETS(16)) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .observe_count (observe_count),
        .query_count   (query_count)
    );

    always #1 clk = ~clk;

    // Receiver stalls at random according to the current phase.
    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog over cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("streaming_quantile_sketch test failed");
            $finish;
        end
    end

    // Present one word and hold it until the sketch takes it.
    task automatic send_word(input logic mode, input logic [31:0] value,
                             input logic [16:0] frac);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.mode <= mode;
        item.sample <= value;
        item.fraction <= frac;
        do
            @(posedge clk);
        while (!item.ready);
    endtask

    // Random word: mostly observes from a narrow band, some queries.
    task automatic send_random();
        logic [31:0] value;
        logic [16:0] frac;
        case ($urandom_range(9))
            0: value = $urandom();
            1: value = ($urandom_range(1)) ? EMPTY_MEAN : 32'h8000_0000;
            default: value = 32'($urandom_range(4000)) - 32'd2000;
        endcase
        frac = ($urandom_range(9) == 0) ? 17'($urandom()) : 17'($urandom_range(65536));
        if ($urandom_range(99) < 30)
            send_word(MODE_QUERY, $urandom(), frac);
        else
            send_word(MODE_OBSERVE, value, 17'($urandom()));
    endtask

    initial
    begin
        item.valid <= 1'b0;
        item.mode <= MODE_OBSERVE;
        item.sample <= '0;
        item.fraction <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty query, extreme samples, extreme fractions.
        send_word(MODE_QUERY, 32'hFFFF_FFFF, 17'd65536);
        send_word(MODE_QUERY, 32'h0, 17'd0);
        send_word(MODE_OBSERVE, 32'h0001_0000, 17'h1FFFF);
        send_word(MODE_QUERY, 32'h0, 17'd32768);
        send_word(MODE_OBSERVE, EMPTY_MEAN, 17'd0);
        send_word(MODE_OBSERVE, 32'h8000_0000, 17'd0);
        send_word(MODE_OBSERVE, 32'hFFFF_FFFF, 17'd0);
        send_word(MODE_OBSERVE, 32'h0, 17'd0);
        for (int i = 0; i < 10; i++)
            send_word(MODE_OBSERVE, 32'(i * 7) - 32'd30, 17'd0);
        send_word(MODE_QUERY, 32'h0, 17'd0);
        send_word(MODE_QUERY, 32'h0, 17'd65536);
        send_word(MODE_QUERY, 32'h0, 17'h1FFFF);
        send_word(MODE_QUERY, 32'h0, 17'd65535);
        send_word(MODE_QUERY, 32'h0, 17'd1);

        // Random words in three idling phases.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 28;
            end
            else if (i == 2 * RANDOM_WORDS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random();
        end
        item.valid <= 1'b0;

        // Drain outstanding answers, then let the last observe finish.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d observe words and %0d query words,", observe_count, query_count);
        $display("including empty, extreme-sample and out-of-range fraction cases.");
        if (fail_count == 0)
            $display("streaming_quantile_sketch test passed");
        else
            $display("streaming_quantile_sketch test failed");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/qs_pkg.sv
rtl/qs_in_if.sv
rtl/qs_out_if.sv
rtl/qs_ram.sv
rtl/qs_div.sv
rtl/streaming_quantile_sketch.sv
bench/qs_checker.sv
bench/tb.sv
